>>> rtl/core/rational_arith_reduce_defines.svh
// ----------------------------------------------------------------------------
// rational_arith_reduce_defines
// assertion macros shared by the fraction reduction core
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RAR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational_arith_reduce: same-cycle check failed");

// next-cycle implication, checked out of reset
`define RAR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational_arith_reduce: next-cycle check failed");

`endif

>>> rtl/core/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// types and constants of the fraction arithmetic and reduction core
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int RAR_OPERAND_WIDTH = 16;
    localparam int RAR_RES_NUM_W     = 33;
    localparam int RAR_RES_DEN_W     = 31;
    localparam int RAR_M_DATA_W      = ((RAR_RES_NUM_W + RAR_RES_DEN_W + 1 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } rar_op_t;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_MUL    = 8'b0000_0010,
        S_SETUP  = 8'b0000_0100,
        S_TWOS   = 8'b0000_1000,
        S_REDUCE = 8'b0001_0000,
        S_DIVN   = 8'b0010_0000,
        S_DIVD   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } rar_state_t;

endpackage

>>> rtl/core/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce: signed fraction add/sub/mul/div reduced to lowest terms
// from input to result valid: cross products, setup, stripping of k common factors
// of two, g binary gcd steps on one shared subtractor, then two restoring divisions
// of 2*OPERAND_WIDTH steps each; a zero result skips to output, an error goes straight there
// one transaction at a time, next accepted in the cycle after the result register loads,
// a result left waiting holds the core; sync reset clears state and the output valid
// ----------------------------------------------------------------------------
`include "rational_arith_reduce_defines.svh"

module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int  OPERAND_WIDTH = RAR_OPERAND_WIDTH,
    localparam int S_DATA_W      = ((2 + 4 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // req_type, left_num, left_den, right_num, right_den
    input  logic [S_DATA_W-1:0]     s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // result_num, result_den, status
    output logic [RAR_M_DATA_W-1:0] m_tdata
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W;
    localparam int NW = 2 * W + 1;
    localparam int MW = 2 * W;
    localparam int CW = $clog2(MW);
    localparam int XN = (MW > RAR_RES_NUM_W) ? MW : RAR_RES_NUM_W;
    localparam int XD = (MW > RAR_RES_DEN_W) ? MW : RAR_RES_DEN_W;
    localparam int PAD_W = RAR_M_DATA_W - RAR_RES_NUM_W - RAR_RES_DEN_W - 1;

    rar_state_t state_reg, state_next;
    rar_op_t    op_reg, op_next;
    logic signed [W-1:0]  a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [NW-1:0] n_reg, n_next;
    logic signed [PW-1:0] q_reg, q_next;
    logic [MW-1:0] u_reg, u_next, v_reg, v_next;
    logic [MW-1:0] nq_reg, nq_next, dq_reg, dq_next, rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic neg_reg, neg_next, err_reg, err_next, zero_reg, zero_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [RAR_M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    rar_op_t             s_op;
    logic signed [W-1:0] s_a, s_b, s_c, s_d;
    logic signed [W-1:0] mul_x, mul_y;
    logic [MW:0]         sub_a, sub_b, diff;
    logic                dvd_msb, div_last;
    logic signed [NW-1:0] n_abs;
    logic signed [PW-1:0] q_abs;
    logic [XN-1:0]       num_x, num_s;
    logic [XD-1:0]       den_x;
    logic [RAR_RES_NUM_W-1:0] res_num;
    logic [RAR_RES_DEN_W-1:0] res_den;
    logic                res_status;

    assign s_op = rar_op_t'(s_tdata[1:0]);
    assign s_a  = s_tdata[2 +: W];
    assign s_b  = s_tdata[2 + W +: W];
    assign s_c  = s_tdata[2 + 2 * W +: W];
    assign s_d  = s_tdata[2 + 3 * W +: W];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // product operand selection
    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin
                mul_x = a_reg;
                mul_y = (op_reg == OP_MUL) ? c_reg : d_reg;
            end
            2'd1: begin
                mul_x = b_reg;
                mul_y = (op_reg == OP_MUL) ? d_reg : c_reg;
            end
            default: begin
                mul_x = b_reg;
                mul_y = d_reg;
            end
        endcase
    end

    // shared subtractor: gcd reduction and restoring division
    assign dvd_msb  = (state_reg == S_DIVN) ? nq_reg[MW-1] : dq_reg[MW-1];
    assign div_last = (cnt_reg == CW'(MW - 1));
    always_comb begin
        if (state_reg == S_DIVN || state_reg == S_DIVD) begin
            sub_a = {rem_reg, dvd_msb};
        end else begin
            sub_a = {1'b0, u_reg};
        end
        sub_b = {1'b0, v_reg};
    end
    assign diff = sub_a - sub_b;

    assign n_abs = n_reg[NW-1] ? -n_reg : n_reg;
    assign q_abs = q_reg[PW-1] ? -q_reg : q_reg;

    // result assembly
    always_comb begin
        num_x = XN'(nq_reg);
        num_s = neg_reg ? (~num_x + XN'(1)) : num_x;
        den_x = XD'(dq_reg);
        if (err_reg) begin
            res_num    = '0;
            res_den    = '0;
            res_status = 1'b1;
        end else if (zero_reg) begin
            res_num    = '0;
            res_den    = RAR_RES_DEN_W'(1);
            res_status = 1'b0;
        end else begin
            res_num    = num_s[RAR_RES_NUM_W-1:0];
            res_den    = den_x[RAR_RES_DEN_W-1:0];
            res_status = 1'b0;
        end
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        c_next        = c_reg;
        d_next        = d_reg;
        prod_next     = mul_x * mul_y;
        n_next        = n_reg;
        q_next        = q_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        nq_next       = nq_reg;
        dq_next       = dq_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;
        err_next      = err_reg;
        zero_next     = zero_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next   = s_op;
                    a_next    = s_a;
                    b_next    = s_b;
                    c_next    = s_c;
                    d_next    = s_d;
                    cnt_next  = '0;
                    zero_next = 1'b0;
                    err_next  = (s_b == '0) || (s_d == '0) || (s_op == OP_DIV && s_c == '0);
                    if ((s_b == '0) || (s_d == '0) || (s_op == OP_DIV && s_c == '0)) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL: begin
                cnt_next = cnt_reg + CW'(1);
                case (cnt_reg[1:0])
                    2'd1: n_next = {prod_reg[PW-1], prod_reg};
                    2'd2: begin
                        case (op_reg)
                            OP_ADD:  n_next = n_reg + {prod_reg[PW-1], prod_reg};
                            OP_SUB:  n_next = n_reg - {prod_reg[PW-1], prod_reg};
                            default: q_next = prod_reg;
                        endcase
                    end
                    2'd3: begin
                        if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                            q_next = prod_reg;
                        end
                        state_next = S_SETUP;
                    end
                    default: ;
                endcase
            end
            S_SETUP: begin
                u_next    = n_abs[MW-1:0];
                v_next    = q_abs[MW-1:0];
                neg_next  = n_reg[NW-1] ^ q_reg[PW-1];
                zero_next = (n_reg == '0);
                if (n_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_TWOS;
                end
            end
            S_TWOS: begin
                // strip common factors of two from both terms
                if (u_reg[0] || v_reg[0]) begin
                    nq_next    = u_reg;
                    dq_next    = v_reg;
                    state_next = S_REDUCE;
                end else begin
                    u_next = u_reg >> 1;
                    v_next = v_reg >> 1;
                end
            end
            S_REDUCE: begin
                if (u_reg == '0 || v_reg == '0) begin
                    if (v_reg == '0) begin
                        v_next = u_reg;
                    end
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = S_DIVN;
                end else if (!u_reg[0]) begin
                    u_next = u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_next = v_reg >> 1;
                end else if (diff[MW]) begin
                    u_next = v_reg;
                    v_next = u_reg;
                end else begin
                    u_next = diff[MW-1:0];
                end
            end
            S_DIVN, S_DIVD: begin
                if (!diff[MW]) begin
                    rem_next = diff[MW-1:0];
                end else begin
                    rem_next = sub_a[MW-1:0];
                end
                if (state_reg == S_DIVN) begin
                    nq_next = {nq_reg[MW-2:0], ~diff[MW]};
                end else begin
                    dq_next = {dq_reg[MW-2:0], ~diff[MW]};
                end
                cnt_next = cnt_reg + CW'(1);
                if (div_last) begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    state_next = (state_reg == S_DIVN) ? S_DIVD : S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, res_status, res_den, res_num};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        c_reg       <= c_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        n_reg       <= n_next;
        q_reg       <= q_next;
        u_reg       <= u_next;
        v_reg       <= v_next;
        nq_reg      <= nq_next;
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        neg_reg     <= neg_next;
        err_reg     <= err_next;
        zero_reg    <= zero_next;
        m_tdata_reg <= m_tdata_next;
    end

    // gcd never loses its nonzero term, divisor is the odd part of the gcd
    `RAR_ASSERT_IMPL(a_reduce_v_nonzero, aclk, aresetn, state_reg == S_REDUCE, v_reg != '0)
    `RAR_ASSERT_IMPL(a_div_odd, aclk, aresetn, (state_reg == S_DIVN) || (state_reg == S_DIVD), v_reg[0])
    `RAR_ASSERT_IMPL(a_div_rem, aclk, aresetn, (state_reg == S_DIVN) || (state_reg == S_DIVD), rem_reg < v_reg)
    `RAR_ASSERT_IMPL(a_status_den, aclk, aresetn, m_tvalid_reg, m_tdata_reg[RAR_RES_NUM_W + RAR_RES_DEN_W] == (m_tdata_reg[RAR_RES_NUM_W +: RAR_RES_DEN_W] == '0))
    `RAR_ASSERT_NEXT(a_err_to_out, aclk, aresetn, (state_reg == S_IDLE) && s_tvalid && (s_tdata[2 + W +: W] == '0), state_reg == S_OUT)

endmodule
